/* rtl/icc_pkg.sv */
// Shared types and constants for the interrupt claim controller.
// No dependencies.
`timescale 1ns / 1ps

package icc_pkg;

    localparam int DEF_NUM_SOURCES  = 64;
    localparam int DEF_NUM_CONTEXTS = 8;
    localparam int DEF_PRIO_BITS    = 3;
    localparam int IRQ_OUT_W        = 8;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LEVEL = 2'd2;

    localparam logic [25:0] PEND_BASE = 26'h000_1000;
    localparam logic [25:0] ENAB_BASE = 26'h000_2000;
    localparam logic [25:0] CTX_BASE  = 26'h020_0000;
    localparam logic [11:0] CLAIM_OFS = 12'h004;

    typedef struct packed {
        logic [1:0]  kind;
        logic [25:0] byte_offset;
        logic [31:0] write_data;
        logic [5:0]  source_id;
        logic        source_level;
    } req_t;

    typedef struct packed {
        logic [31:0]          read_data;
        logic [IRQ_OUT_W-1:0] context_irq;
        logic                 access_error;
    } rsp_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic exec;
        logic prio_capture;
        logic scan_init;
        logic scan_run;
        logic claim_apply;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic prio_read;
        logic claim_read;
        logic scan_done;
    } sts_t;

endpackage

/* rtl/icc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module icc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/icc_datapath.sv */
// Datapath: register decode, pending/service/enable state, priority scan.
// Depends on icc_pkg and icc_ram.
`timescale 1ns / 1ps

module icc_datapath #(
    parameter int NUM_SOURCES  = icc_pkg::DEF_NUM_SOURCES,
    parameter int NUM_CONTEXTS = icc_pkg::DEF_NUM_CONTEXTS,
    parameter int PRIO_BITS    = icc_pkg::DEF_PRIO_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  icc_pkg::cmd_t cmd,
    output icc_pkg::sts_t sts,
    input  icc_pkg::req_t req,
    output icc_pkg::rsp_t rsp
);

    import icc_pkg::*;

    localparam int SRC_W     = $clog2(NUM_SOURCES);
    localparam int SRC_WORDS = (NUM_SOURCES + 31) / 32;
    localparam int WRD_W     = (SRC_WORDS > 1) ? $clog2(SRC_WORDS) : 1;
    localparam int PAD_W     = SRC_WORDS * 32;
    localparam int CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SOURCES + 1);
    localparam int IRQ_N     = (NUM_CONTEXTS < IRQ_OUT_W) ? NUM_CONTEXTS : IRQ_OUT_W;

    function automatic logic [PAD_W-1:0] valid_mask();
        logic [PAD_W-1:0] m;
        m = '0;
        for (int i = 0; i < PAD_W; i++)
        begin
            m[i] = (i != 0) && (i < NUM_SOURCES);
        end
        return m;
    endfunction

    localparam logic [PAD_W-1:0] VALID_MASK = valid_mask();

    req_t                   item_reg;
    logic [NUM_SOURCES-1:0] pend_reg;
    logic [NUM_SOURCES-1:0] insvc_reg;
    logic [NUM_SOURCES-1:0] level_reg;
    logic [PAD_W-1:0]       enab_reg [NUM_CONTEXTS];
    logic [PRIO_BITS-1:0]   thr_reg [NUM_CONTEXTS];
    logic [31:0]            rd_reg;
    rsp_t                   rsp_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       clr_cnt_reg;
    logic                   vld_d_reg;
    logic [SRC_W-1:0]       idx_d_reg;
    logic [IRQ_N-1:0]       found_reg;
    logic [SRC_W-1:0]       best_reg;
    logic [PRIO_BITS-1:0]   bestp_reg;

    logic [25:0]          off;
    logic                 is_bus, is_wr, aligned;
    logic                 in_src, in_pend, in_enab, in_ctx;
    logic [9:0]           src_num;
    logic [9:0]           pw;
    logic [25:0]          en_rel, cx_rel;
    logic [13:0]          ec, tc;
    logic [4:0]           ew;
    logic [11:0]          tr;
    logic                 map_ok, err, act, is_thr;
    logic [CTX_W-1:0]     ctx_sel, claim_ctx;
    logic [WRD_W-1:0]     wsel;
    logic [SRC_W-1:0]     src_idx, sid_idx, cmp_idx;
    logic [15:0]          sid_w;
    logic                 sid_ok, cmp_ok, do_complete;
    logic [PAD_W-1:0]     pend_pad;
    logic [31:0]          rd_exec;
    logic                 ram_we;
    logic [SRC_W-1:0]     ram_waddr, ram_raddr;
    logic [PRIO_BITS-1:0] ram_wdata, ram_rdata;

    always_comb
    begin
        off     = item_reg.byte_offset;
        is_bus  = (item_reg.kind == KIND_READ) || (item_reg.kind == KIND_WRITE);
        is_wr   = (item_reg.kind == KIND_WRITE);
        aligned = (off[1:0] == 2'b00);
        in_src  = (off < PEND_BASE);
        in_pend = !in_src && (off < ENAB_BASE);
        in_enab = (off >= ENAB_BASE) && (off < CTX_BASE);
        in_ctx  = (off >= CTX_BASE);
        src_num = off[11:2];
        pw      = off[11:2];
        en_rel  = off - ENAB_BASE;
        ec      = en_rel[20:7];
        ew      = en_rel[6:2];
        cx_rel  = off - CTX_BASE;
        tc      = cx_rel[25:12];
        tr      = cx_rel[11:0];
        is_thr  = (tr == 12'd0);

        if (in_src)
        begin
            map_ok = int'(src_num) < NUM_SOURCES;
        end
        else if (in_pend)
        begin
            map_ok = int'(pw) < SRC_WORDS;
        end
        else if (in_enab)
        begin
            map_ok = (int'(ec) < NUM_CONTEXTS) && (int'(ew) < SRC_WORDS);
        end
        else
        begin
            map_ok = (int'(tc) < NUM_CONTEXTS) && (tr <= CLAIM_OFS);
        end
        map_ok = map_ok && aligned;
        err    = is_bus && !map_ok;
        act    = is_bus && map_ok;

        ctx_sel   = in_enab ? ec[CTX_W-1:0] : tc[CTX_W-1:0];
        claim_ctx = tc[CTX_W-1:0];
        wsel      = in_pend ? pw[WRD_W-1:0] : ew[WRD_W-1:0];
        src_idx   = src_num[SRC_W-1:0];

        sid_w   = 16'(item_reg.source_id);
        sid_idx = sid_w[SRC_W-1:0];
        sid_ok  = (sid_w != 16'd0) && (int'(sid_w) < NUM_SOURCES);

        cmp_idx = item_reg.write_data[SRC_W-1:0];
        cmp_ok  = (item_reg.write_data != 32'd0)
               && (item_reg.write_data < 32'(NUM_SOURCES));
        do_complete = act && is_wr && in_ctx && !is_thr && cmp_ok
                   && enab_reg[ctx_sel][cmp_idx] && insvc_reg[cmp_idx];

        pend_pad = PAD_W'(pend_reg);
        rd_exec  = '0;
        if (act && !is_wr)
        begin
            if (in_pend)
            begin
                rd_exec = pend_pad[wsel*32 +: 32];
            end
            else if (in_enab)
            begin
                rd_exec = enab_reg[ctx_sel][wsel*32 +: 32];
            end
            else if (in_ctx && is_thr)
            begin
                rd_exec = 32'(thr_reg[ctx_sel]);
            end
        end

        ram_we    = cmd.clr_step
                 || (cmd.exec && act && is_wr && in_src && (src_idx != '0));
        ram_waddr = cmd.clr_step ? clr_cnt_reg[SRC_W-1:0] : src_idx;
        ram_wdata = cmd.clr_step ? '0 : item_reg.write_data[PRIO_BITS-1:0];
        ram_raddr = cmd.scan_run ? cnt_reg[SRC_W-1:0] : src_idx;
    end

    icc_ram #(
        .WIDTH (PRIO_BITS),
        .DEPTH (NUM_SOURCES),
        .AW    (SRC_W)
    ) u_prio_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.exec)
        begin
            rd_reg <= rd_exec;
        end
        if (cmd.prio_capture)
        begin
            rd_reg <= 32'(ram_rdata);
        end
        if (cmd.claim_apply)
        begin
            rd_reg <= 32'(best_reg);
        end
        if (cmd.emit)
        begin
            rsp_reg.read_data    <= rd_reg;
            rsp_reg.context_irq  <= IRQ_OUT_W'(found_reg);
            rsp_reg.access_error <= err;
        end
    end

    // interrupt state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            insvc_reg <= '0;
            level_reg <= '0;
            for (int c = 0; c < NUM_CONTEXTS; c++)
            begin
                enab_reg[c] <= '0;
                thr_reg[c]  <= '0;
            end
        end
        else
        begin
            if (cmd.exec)
            begin
                if ((item_reg.kind == KIND_LEVEL) && sid_ok)
                begin
                    level_reg[sid_idx] <= item_reg.source_level;
                    if (item_reg.source_level && !insvc_reg[sid_idx])
                    begin
                        pend_reg[sid_idx] <= 1'b1;
                    end
                end
                if (act && is_wr && in_enab)
                begin
                    enab_reg[ctx_sel][wsel*32 +: 32] <=
                        item_reg.write_data & VALID_MASK[wsel*32 +: 32];
                end
                if (act && is_wr && in_ctx && is_thr)
                begin
                    thr_reg[ctx_sel] <= item_reg.write_data[PRIO_BITS-1:0];
                end
                if (do_complete)
                begin
                    insvc_reg[cmp_idx] <= 1'b0;
                    if (level_reg[cmp_idx])
                    begin
                        pend_reg[cmp_idx] <= 1'b1;
                    end
                end
            end
            if (cmd.claim_apply && (best_reg != '0))
            begin
                pend_reg[best_reg]  <= 1'b0;
                insvc_reg[best_reg] <= 1'b1;
            end
        end
    end

    // clearing pass and source scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
            vld_d_reg   <= 1'b0;
            idx_d_reg   <= '0;
            found_reg   <= '0;
            best_reg    <= '0;
            bestp_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.scan_init)
            begin
                cnt_reg   <= '0;
                vld_d_reg <= 1'b0;
                found_reg <= '0;
                best_reg  <= '0;
                bestp_reg <= '0;
            end
            else if (cmd.scan_run)
            begin
                if (cnt_reg != CNT_W'(NUM_SOURCES))
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    vld_d_reg <= 1'b1;
                    idx_d_reg <= cnt_reg[SRC_W-1:0];
                end
                else
                begin
                    vld_d_reg <= 1'b0;
                end
                if (vld_d_reg && (idx_d_reg != '0) && pend_reg[idx_d_reg])
                begin
                    for (int c = 0; c < IRQ_N; c++)
                    begin
                        if (enab_reg[c][idx_d_reg] && (ram_rdata > thr_reg[c]))
                        begin
                            found_reg[c] <= 1'b1;
                        end
                    end
                    if (enab_reg[claim_ctx][idx_d_reg]
                        && (ram_rdata > thr_reg[claim_ctx])
                        && (ram_rdata > bestp_reg))
                    begin
                        best_reg  <= idx_d_reg;
                        bestp_reg <= ram_rdata;
                    end
                end
            end
        end
    end

    assign sts.clear_done = (clr_cnt_reg == CNT_W'(NUM_SOURCES));
    assign sts.prio_read  = act && in_src && !is_wr;
    assign sts.claim_read = act && in_ctx && !is_thr && !is_wr;
    assign sts.scan_done  = (cnt_reg == CNT_W'(NUM_SOURCES)) && !vld_d_reg;
    assign rsp            = rsp_reg;

`ifndef NO_ASSERTIONS
    a_pend_svc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & insvc_reg) == '0)
        else $error("source both pending and in service");

    a_src0_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg[0] && !insvc_reg[0])
        else $error("source zero became active");

    a_claim_mark: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim_apply && (best_reg != '0) |=> insvc_reg[$past(best_reg)])
        else $error("claimed source not marked in service");
`endif

endmodule

/* rtl/icc_ctrl.sv */
// Controller state machine: request handshake, sequencing of decode, scans and response.
// Depends on icc_pkg.
`timescale 1ns / 1ps

module icc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output icc_pkg::cmd_t cmd,
    input  icc_pkg::sts_t sts
);

    import icc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_PRIO,
        S_CLAIM,
        S_IRQ,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CLEAR: cmd.clr_step = !sts.clear_done;
            S_IDLE:  cmd.load = req_valid;
            S_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.scan_init = 1'b1;
            end
            S_PRIO:  cmd.prio_capture = 1'b1;
            S_CLAIM:
            begin
                cmd.scan_run    = !sts.scan_done;
                cmd.claim_apply = sts.scan_done;
                cmd.scan_init   = sts.scan_done;
            end
            S_IRQ:   cmd.scan_run = !sts.scan_done;
            S_EMIT:  cmd.emit = !rsp_valid_reg || rsp_ready;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && !cmd.emit)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (sts.clear_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (sts.prio_read)
                    begin
                        state_reg <= S_PRIO;
                    end
                    else if (sts.claim_read)
                    begin
                        state_reg <= S_CLAIM;
                    end
                    else
                    begin
                        state_reg <= S_IRQ;
                    end
                end
                S_PRIO:  state_reg <= S_IRQ;
                S_CLAIM:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= S_IRQ;
                    end
                end
                S_IRQ:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

`ifndef NO_ASSERTIONS
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp_valid_reg)
        else $error("response register not marked full after emit");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_EXEC))
        else $error("accepted request not decoded next cycle");

    a_scan_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan_run && (cmd.exec || cmd.clr_step)))
        else $error("scan overlaps decode or clearing");
`endif

endmodule

/* rtl/interrupt_claim_controller.sv */
// Platform-level interrupt controller: register map, claim/complete, source levels.
// Top level; instantiates icc_ctrl and icc_datapath, uses icc_pkg.
//
// Usage: one request channel (req_valid/req_ready, payload req) carries bus
// reads, bus writes and source line level changes; one response channel
// (rsp_valid/rsp_ready, payload rsp) returns exactly one response per request
// with read data, the per-context interrupt lines and an access error flag.
// A request is taken only in the idle state, one at a time.
// Most requests pass through decode and one source scan before the response;
// a priority read adds a capture state, and a claim read adds a further scan
// ahead of the interrupt scan. The source scan reads one priority per cycle
// through the single read port of the priority RAM.
// After reset a clearing pass zeroes the priority RAM; req_ready stays low
// until it finishes. All other interrupt state resets at once.
// A finished response sits in an output register; the next request is taken
// while it waits, and a stalled receiver holds the block only when the
// following response is ready to be written.
`timescale 1ns / 1ps

module interrupt_claim_controller #(
    parameter int NUM_SOURCES  = icc_pkg::DEF_NUM_SOURCES,
    parameter int NUM_CONTEXTS = icc_pkg::DEF_NUM_CONTEXTS,
    parameter int PRIO_BITS    = icc_pkg::DEF_PRIO_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  icc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output icc_pkg::rsp_t rsp
);

    import icc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    icc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    icc_datapath #(
        .NUM_SOURCES  (NUM_SOURCES),
        .NUM_CONTEXTS (NUM_CONTEXTS),
        .PRIO_BITS    (PRIO_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

/* bench/tb.sv */
// Self-checking bench for interrupt_claim_controller: register map, claim and
// complete, source line levels, checked request by request. Depends on icc_pkg and interrupt_claim_controller.
`timescale 1ns / 1ps

module tb;
    import icc_pkg::*;

    localparam int NSRC  = DEF_NUM_SOURCES;
    localparam int NCTX  = DEF_NUM_CONTEXTS;
    localparam int PBITS = DEF_PRIO_BITS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    interrupt_claim_controller dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    // controller state mirror
    logic [PBITS-1:0] prio_m [NSRC];
    logic [NSRC-1:0]  pend_m;
    logic [NSRC-1:0]  serv_m;
    logic [NSRC-1:0]  line_m;
    logic [NSRC-1:0]  enab_m [NCTX];
    logic [PBITS-1:0] thr_m  [NCTX];

    req_t request_q[$];
    rsp_t expected_rsp_q[$];
    int   fail_count;
    int   idle_cycles;
    bit   no_idle;
    bit   hold_off;
    int   src_gap;
    int   snk_gap;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int best_of(int c);
        int best;
        int bp;
        best = 0;
        bp = 0;
        for (int s = 1; s < NSRC; s++)
            if (pend_m[s] && enab_m[c][s] && prio_m[s] > thr_m[c] && prio_m[s] > bp)
            begin
                best = s;
                bp = prio_m[s];
            end
        return best;
    endfunction

    function automatic rsp_t predict_response(req_t r);
        rsp_t o;
        logic [31:0] off;
        logic [31:0] rel;
        int c;
        int w;
        int s;
        o = '0;
        off = {6'd0, r.byte_offset};
        if (r.kind == KIND_READ || r.kind == KIND_WRITE)
        begin
            if (off[1:0] != 2'b00)
                o.access_error = 1'b1;
            else if (off < PEND_BASE)
            begin
                s = off >> 2;
                if (s >= NSRC)
                    o.access_error = 1'b1;
                else if (s != 0)
                begin
                    if (r.kind == KIND_WRITE)
                        prio_m[s] = r.write_data[PBITS-1:0];
                    else
                        o.read_data = prio_m[s];
                end
            end
            else if (off < ENAB_BASE)
            begin
                w = (off - PEND_BASE) >> 2;
                if (w >= NSRC / 32)
                    o.access_error = 1'b1;
                else if (r.kind == KIND_READ)
                    o.read_data = pend_m[w*32 +: 32];
            end
            else if (off < CTX_BASE)
            begin
                rel = off - ENAB_BASE;
                c = rel / 32'h80;
                w = (rel % 32'h80) >> 2;
                if (c >= NCTX || w >= NSRC / 32)
                    o.access_error = 1'b1;
                else if (r.kind == KIND_WRITE)
                begin
                    enab_m[c][w*32 +: 32] = r.write_data;
                    enab_m[c][0] = 1'b0;
                end
                else
                    o.read_data = enab_m[c][w*32 +: 32];
            end
            else
            begin
                rel = off - CTX_BASE;
                c = rel / 32'h1000;
                if (c >= NCTX || (rel % 32'h1000) > CLAIM_OFS)
                    o.access_error = 1'b1;
                else if ((rel % 32'h1000) == 0)
                begin
                    if (r.kind == KIND_WRITE)
                        thr_m[c] = r.write_data[PBITS-1:0];
                    else
                        o.read_data = thr_m[c];
                end
                else if (r.kind == KIND_WRITE)
                begin
                    s = r.write_data[5:0];
                    if (r.write_data != 0 && r.write_data < NSRC && enab_m[c][s] && serv_m[s])
                    begin
                        serv_m[s] = 1'b0;
                        if (line_m[s])
                            pend_m[s] = 1'b1;
                    end
                end
                else
                begin
                    s = best_of(c);
                    if (s != 0)
                    begin
                        pend_m[s] = 1'b0;
                        serv_m[s] = 1'b1;
                    end
                    o.read_data = s;
                end
            end
        end
        else if (r.kind == KIND_LEVEL && r.source_id != 0)
        begin
            line_m[r.source_id] = r.source_level;
            if (r.source_level && !serv_m[r.source_id])
                pend_m[r.source_id] = 1'b1;
        end
        for (int k = 0; k < NCTX && k < IRQ_OUT_W; k++)
            if (best_of(k) != 0)
                o.context_irq[k] = 1'b1;
        return o;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            src_gap <= 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (req_valid)
                expected_rsp_q.push_back(predict_response(req));
            if (src_gap > 0)
            begin
                req_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (request_q.size() != 0)
            begin
                req <= request_q.pop_front();
                req_valid <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 16);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            snk_gap <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t unexpected response: got %h", $time, rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsp_q.pop_front();
                    if (e.read_data !== rsp.read_data || e.context_irq !== rsp.context_irq
                        || e.access_error !== rsp.access_error)
                    begin
                        $display("%0t mismatch: expected %h/%h/%b actual %h/%h/%b", $time,
                                 e.read_data, e.context_irq, e.access_error,
                                 rsp.read_data, rsp.context_irq, rsp.access_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (hold_off)
                rsp_ready <= 1'b0;
            else if (snk_gap > 0)
            begin
                rsp_ready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                rsp_ready <= 1'b0;
                snk_gap <= $urandom_range(0, 15);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic req_t bus_op(logic [1:0] k, logic [25:0] off, logic [31:0] d);
        req_t r;
        r = '0;
        r.kind = k;
        r.byte_offset = off;
        r.write_data = d;
        r.source_id = 6'($urandom);
        r.source_level = 1'($urandom);
        return r;
    endfunction

    function automatic req_t line_op(int s, bit lvl);
        req_t r;
        r = '0;
        r.kind = KIND_LEVEL;
        r.byte_offset = 26'($urandom);
        r.write_data = $urandom;
        r.source_id = 6'(s);
        r.source_level = lvl;
        return r;
    endfunction

    function automatic logic [25:0] rand_offset();
        int c;
        c = $urandom_range(0, NCTX - 1);
        case ($urandom_range(0, 9))
            0, 1: return 26'($urandom_range(0, NSRC + 1) * 4);
            2:    return PEND_BASE + 26'($urandom_range(0, 2) * 4);
            3, 4: return ENAB_BASE + 26'($urandom_range(0, NCTX) * 32'h80
                                        + $urandom_range(0, 2) * 4);
            5:    return CTX_BASE + 26'(c * 32'h1000);
            6, 7: return CTX_BASE + 26'(c * 32'h1000) + 26'(CLAIM_OFS);
            8:    return CTX_BASE + 26'($urandom_range(0, NCTX) * 32'h1000
                                        + $urandom_range(0, 3) * 4);
            default: return 26'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_data();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(0, NSRC + 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t rand_request();
        logic [1:0] k;
        k = 2'($urandom_range(0, 7) < 3 ? KIND_LEVEL : $urandom_range(0, 3));
        if (k == KIND_LEVEL)
            return line_op($urandom_range(0, NSRC - 1), $urandom_range(0, 1));
        return bus_op(k, rand_offset(), rand_data());
    endfunction

    initial
    begin
        int c;
        int s;
        bit hold_done;
        for (int i = 0; i < NSRC; i++)
            prio_m[i] = '0;
        for (int i = 0; i < NCTX; i++)
        begin
            enab_m[i] = '0;
            thr_m[i] = '0;
        end
        pend_m = '0;
        serv_m = '0;
        line_m = '0;
        fail_count = 0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        hold_done = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: edges of the map, source zero, claim and complete
        request_q.push_back(bus_op(KIND_WRITE, 26'd4, 32'hFFFF_FFFF));
        request_q.push_back(bus_op(KIND_WRITE, 26'd0, 32'h7));
        request_q.push_back(bus_op(KIND_READ, 26'd0, 32'h0));
        request_q.push_back(bus_op(KIND_WRITE, 26'((NSRC - 1) * 4), 32'h5));
        request_q.push_back(bus_op(KIND_READ, 26'(NSRC * 4), 32'h0));
        request_q.push_back(bus_op(KIND_READ, 26'd6, 32'h0));
        request_q.push_back(bus_op(KIND_READ, 26'h3FF_FFFF, 32'h0));
        request_q.push_back(bus_op(KIND_WRITE, ENAB_BASE, 32'hFFFF_FFFF));
        request_q.push_back(bus_op(KIND_WRITE, ENAB_BASE + 26'd4, 32'hFFFF_FFFF));
        request_q.push_back(bus_op(KIND_READ, ENAB_BASE, 32'h0));
        request_q.push_back(line_op(0, 1'b1));
        request_q.push_back(line_op(1, 1'b1));
        request_q.push_back(line_op(NSRC - 1, 1'b1));
        request_q.push_back(bus_op(KIND_WRITE, PEND_BASE, 32'hFFFF_FFFF));
        request_q.push_back(bus_op(KIND_READ, PEND_BASE + 26'd4, 32'h0));
        request_q.push_back(bus_op(KIND_READ, CTX_BASE + 26'(CLAIM_OFS), 32'h0));
        request_q.push_back(bus_op(KIND_READ, CTX_BASE + 26'(CLAIM_OFS), 32'h0));
        request_q.push_back(line_op(NSRC - 1, 1'b0));
        request_q.push_back(bus_op(KIND_WRITE, CTX_BASE + 26'(CLAIM_OFS), NSRC - 1));
        request_q.push_back(bus_op(KIND_WRITE, CTX_BASE + 26'(CLAIM_OFS), 32'd1));
        request_q.push_back(bus_op(KIND_WRITE, CTX_BASE, 32'hFFFF_FFFF));
        request_q.push_back(bus_op(KIND_READ, CTX_BASE + 26'h8, 32'h0));
        request_q.push_back(bus_op(KIND_READ, CTX_BASE + 26'(NCTX * 32'h1000), 32'h0));
        request_q.push_back(bus_op(2'd3, 26'h3FF_FFFF, 32'hFFFF_FFFF));

        // random: sessions of priorities, enables, line raises, claims, completes
        for (int n = 0; n < 520; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                s = $urandom_range(1, NSRC - 1);
                c = $urandom_range(0, NCTX - 1);
                request_q.push_back(bus_op(KIND_WRITE, 26'(s * 4), $urandom));
                request_q.push_back(bus_op(KIND_WRITE,
                    ENAB_BASE + 26'(c * 32'h80 + (s / 32) * 4), $urandom | (1 << (s % 32))));
                request_q.push_back(line_op(s, 1'b1));
                request_q.push_back(bus_op(KIND_READ, CTX_BASE + 26'(c * 32'h1000)
                    + 26'(CLAIM_OFS), $urandom));
                request_q.push_back(bus_op(KIND_WRITE, CTX_BASE + 26'(c * 32'h1000)
                    + 26'(CLAIM_OFS), s));
                n += 4;
            end
            else
                request_q.push_back(rand_request());
            if (n >= 200 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            if (n >= 440)
                no_idle = 1'b1;
            if (request_q.size() > 40)
                wait (request_q.size() < 10);
        end

        wait (request_q.size() == 0 && !req_valid);
        wait (expected_rsp_q.size() == 0);
        repeat (3 * NSRC + 20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
